### sv/c16f_pkg.sv
// Shared constants, burst descriptor type and CRC-16 byte fold for the framer.
package c16f_pkg;

  localparam logic [7:0]  MARK_FIRST  = 8'hAA;
  localparam logic [7:0]  MARK_SECOND = 8'h55;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  localparam int MAX_BURST = 7;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);

  localparam logic [CNT_W-1:0] CNT_ERR   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_BYTE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TAIL  = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(5);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(7);

  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      crc_end;
    logic                      err;
  } burst_t;

  typedef struct packed {
    logic   valid;
    burst_t burst;
  } burst_req_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/c16f_if.sv
// Valid/ready channel interfaces for payload input and wire-byte output.
interface c16f_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [15:0] frame_length;

  modport source (output valid, output payload_byte, output frame_length, input ready);
  modport sink   (input valid, input payload_byte, input frame_length, output ready);
endinterface

interface c16f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       burst_last;
  logic       length_error;

  modport source (output valid, output out_byte, output frame_end, output burst_last,
                  output length_error, input ready);
  modport sink   (input valid, input out_byte, input frame_end, input burst_last,
                  input length_error, output ready);
endinterface

### sv/c16f_emit.sv
// Burst shift register and output register: sends one wire byte per cycle while out_ch.ready holds.
module c16f_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  c16f_pkg::burst_req_t req,
  output logic                req_ready,
  c16f_out_if.source          out_ch
);

  logic [c16f_pkg::MAX_BURST-1:0][7:0] q_bytes_r, q_bytes_nxt;
  logic [c16f_pkg::CNT_W-1:0]          q_cnt_r, q_cnt_nxt;
  logic                                q_end_r, q_end_nxt;
  logic                                q_err_r, q_err_nxt;

  logic       o_valid_r, o_valid_nxt;
  logic [7:0] o_byte_r, o_byte_nxt;
  logic       o_end_r, o_end_nxt;
  logic       o_last_r, o_last_nxt;
  logic       o_err_r, o_err_nxt;

  logic o_load;
  logic q_one;

  assign q_one     = (q_cnt_r == c16f_pkg::CNT_W'(1));
  assign o_load    = (q_cnt_r != '0) && (!o_valid_r || out_ch.ready);
  assign req_ready = (q_cnt_r == '0) || (o_load && q_one);

  always_comb begin
    q_bytes_nxt = q_bytes_r;
    q_cnt_nxt   = q_cnt_r;
    q_end_nxt   = q_end_r;
    q_err_nxt   = q_err_r;
    o_valid_nxt = o_valid_r;
    o_byte_nxt  = o_byte_r;
    o_end_nxt   = o_end_r;
    o_last_nxt  = o_last_r;
    o_err_nxt   = o_err_r;

    if (o_load) begin
      o_valid_nxt = 1'b1;
      o_byte_nxt  = q_bytes_r[0];
      o_last_nxt  = q_one;
      o_end_nxt   = q_end_r && q_one;
      o_err_nxt   = q_err_r;
      q_bytes_nxt = {8'h00, q_bytes_r[c16f_pkg::MAX_BURST-1:1]};
      q_cnt_nxt   = q_cnt_r - c16f_pkg::CNT_W'(1);
    end else if (out_ch.ready) begin
      o_valid_nxt = 1'b0;
    end

    if (req.valid && req_ready) begin
      q_bytes_nxt = req.burst.bytes;
      q_cnt_nxt   = req.burst.count;
      q_end_nxt   = req.burst.crc_end;
      q_err_nxt   = req.burst.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r   <= '0;
      o_valid_r <= 1'b0;
    end else begin
      q_cnt_r   <= q_cnt_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_bytes_r <= q_bytes_nxt;
    q_end_r   <= q_end_nxt;
    q_err_r   <= q_err_nxt;
    o_byte_r  <= o_byte_nxt;
    o_end_r   <= o_end_nxt;
    o_last_r  <= o_last_nxt;
    o_err_r   <= o_err_nxt;
  end

  assign out_ch.valid        = o_valid_r;
  assign out_ch.out_byte     = o_byte_r;
  assign out_ch.frame_end    = o_end_r;
  assign out_ch.burst_last   = o_last_r;
  assign out_ch.length_error = o_err_r;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_end_r) |-> o_last_r)
    else $error("frame end not on last result of item");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_err_r) |-> (o_last_r && !o_end_r && (o_byte_r == 8'h00)))
    else $error("length error result malformed");

  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    req_ready |-> (q_cnt_r <= c16f_pkg::CNT_W'(1)))
    else $error("new item taken over pending results");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && req_ready) |=> (q_cnt_r != '0))
    else $error("item loaded with no results");
`endif

endmodule

### sv/crc16_packet_framer.sv
// Top level: length-prefixed packet framer with CRC-16/CCITT-FALSE trailer.
//
//   channel | dir | payload                                          | handshake
//   in_ch   | in  | payload_byte[8], frame_length[16]                | valid/ready
//   out_ch  | out | out_byte[8], frame_end, burst_last, length_error  | valid/ready
//
// An item yields 1 result (inside a frame or zero-length error), 3 (last byte of a
// frame), 5 (frame start) or 7 (one-byte frame); results leave one at a time through
// the single-byte output port, and the CRC fold of a byte is combinational.
// The next item is taken in the cycle its predecessor's last result enters the output
// register, so single-result items flow back to back while out_ch.ready holds.
// Synchronous active-low reset clears frame state and empties both stages.
module crc16_packet_framer (
  input  logic       clk,
  input  logic       rst_n,
  c16f_in_if.sink    in_ch,
  c16f_out_if.source out_ch
);

  logic        in_frame_r, in_frame_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic        accept;
  logic        start;
  logic        zero_len;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic [15:0] left_base;
  logic [15:0] left_new;
  logic        done;

  c16f_pkg::burst_req_t req;
  logic                 req_ready;

  assign in_ch.ready = req_ready;
  assign accept      = in_ch.valid && req_ready;

  assign start     = !in_frame_r;
  assign zero_len  = start && (in_ch.frame_length == 16'h0000);
  assign crc_base  = start ? c16f_pkg::CRC_INIT : crc_r;
  assign crc_new   = c16f_pkg::crc_fold(crc_base, in_ch.payload_byte);
  assign left_base = start ? in_ch.frame_length : bytes_left_r;
  assign left_new  = left_base - 16'd1;
  assign done      = (left_new == 16'h0000);

  always_comb begin
    req.valid         = in_ch.valid;
    req.burst.bytes   = '0;
    req.burst.count   = c16f_pkg::CNT_BYTE;
    req.burst.crc_end = 1'b0;
    req.burst.err     = 1'b0;
    if (zero_len) begin
      req.burst.count = c16f_pkg::CNT_ERR;
      req.burst.err   = 1'b1;
    end else if (start) begin
      req.burst.bytes[0] = c16f_pkg::MARK_FIRST;
      req.burst.bytes[1] = c16f_pkg::MARK_SECOND;
      req.burst.bytes[2] = in_ch.frame_length[15:8];
      req.burst.bytes[3] = in_ch.frame_length[7:0];
      req.burst.bytes[4] = in_ch.payload_byte;
      req.burst.bytes[5] = crc_new[15:8];
      req.burst.bytes[6] = crc_new[7:0];
      req.burst.count    = done ? c16f_pkg::CNT_FULL : c16f_pkg::CNT_START;
      req.burst.crc_end  = done;
    end else begin
      req.burst.bytes[0] = in_ch.payload_byte;
      req.burst.bytes[1] = crc_new[15:8];
      req.burst.bytes[2] = crc_new[7:0];
      req.burst.count    = done ? c16f_pkg::CNT_TAIL : c16f_pkg::CNT_BYTE;
      req.burst.crc_end  = done;
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    if (accept && !zero_len) begin
      in_frame_nxt   = !done;
      bytes_left_nxt = left_new;
      crc_nxt        = done ? c16f_pkg::CRC_INIT : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bytes_left_r <= 16'h0000;
      crc_r        <= c16f_pkg::CRC_INIT;
    end else begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
    end
  end

  c16f_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_idle_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (crc_r == c16f_pkg::CRC_INIT))
    else $error("CRC not reinitialized between frames");

  a_frame_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (bytes_left_r != 16'h0000))
    else $error("open frame with no bytes left");

  a_zero_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && zero_len) |=> !in_frame_r)
    else $error("zero-length start opened a frame");
`endif

endmodule

### tb/crc16_packet_framer_checker.sv
// Checker for the CRC-16 framer: predicts wire bytes per accepted item and compares results.
module crc16_packet_framer_checker (
  input  logic clk,
  input  logic rst_n,
  c16f_in_if   in_ch,
  c16f_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       burst_last;
    logic       length_error;
  } wire_byte_t;

  wire_byte_t  wire_q[$];
  logic        frame_open;
  logic [15:0] bytes_left;
  logic [15:0] crc_run;

  // CCITT-FALSE, one bit at a time, MSB first
  function automatic logic [15:0] crc16_ccitt_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? c16f_pkg::CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  task automatic frame_item(input logic [7:0] b, input logic [15:0] len);
    wire_byte_t burst[c16f_pkg::MAX_BURST];
    int         n;
    n = 0;
    if (!frame_open && len == 16'h0000) begin
      burst[0] = '{8'h00, 1'b0, 1'b0, 1'b1};
      n = 1;
    end else begin
      if (!frame_open) begin
        burst[0]   = '{c16f_pkg::MARK_FIRST, 1'b0, 1'b0, 1'b0};
        burst[1]   = '{c16f_pkg::MARK_SECOND, 1'b0, 1'b0, 1'b0};
        burst[2]   = '{len[15:8], 1'b0, 1'b0, 1'b0};
        burst[3]   = '{len[7:0], 1'b0, 1'b0, 1'b0};
        n          = 4;
        frame_open = 1'b1;
        bytes_left = len;
        crc_run    = c16f_pkg::CRC_INIT;
      end
      burst[n]   = '{b, 1'b0, 1'b0, 1'b0};
      n++;
      crc_run    = crc16_ccitt_byte(crc_run, b);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'h0000) begin
        burst[n]     = '{crc_run[15:8], 1'b0, 1'b0, 1'b0};
        burst[n + 1] = '{crc_run[7:0], 1'b1, 1'b0, 1'b0};
        n            = n + 2;
        frame_open   = 1'b0;
        crc_run      = c16f_pkg::CRC_INIT;
      end
    end
    burst[n - 1].burst_last = 1'b1;
    for (int i = 0; i < n; i++) begin
      wire_q.push_back(burst[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    wire_byte_t head;
    if (!rst_n) begin
      frame_open = 1'b0;
      bytes_left = 16'h0000;
      crc_run    = c16f_pkg::CRC_INIT;
      wire_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        frame_item(in_ch.payload_byte, in_ch.frame_length);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (wire_q.size() == 0) begin
          $error("result with nothing expected: out_byte %0h", out_ch.out_byte);
          fail_count++;
        end else begin
          head = wire_q.pop_front();
          check_field("out_byte", head.data, out_ch.out_byte);
          check_field("frame_end", 8'(head.frame_end), 8'(out_ch.frame_end));
          check_field("burst_last", 8'(head.burst_last), 8'(out_ch.burst_last));
          check_field("length_error", 8'(head.length_error), 8'(out_ch.length_error));
        end
      end
    end
    pending <= wire_q.size();
  end

endmodule

### tb/crc16_packet_framer_tb.sv
// Testbench top for the CRC-16 framer: payload stimulus, output stalls, watchdog and verdict.
module crc16_packet_framer_tb;

  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   results_taken;
  bit   in_quiet;
  bit   out_quiet;

  c16f_in_if  in_ch ();
  c16f_out_if out_ch ();

  crc16_packet_framer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  crc16_packet_framer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL crc16_packet_framer");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_item(input logic [7:0] b, input logic [15:0] len);
    int gap;
    if ($urandom_range(0, 15) == 0) begin
      in_quiet = !in_quiet;
    end
    gap = in_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= b;
    in_ch.frame_length <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Result side: random stalls, plus long hold-offs so the framer backs up into its input.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        out_quiet = !out_quiet;
      end
      stall = out_quiet ? 0 : $urandom_range(0, 8);
      if (results_taken == 40 || results_taken == 250) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    int sent;
    int len;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= 8'h00;
    in_ch.frame_length <= 16'h0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero length at frame start, then one-byte frames
    send_item(8'h00, 16'h0000);
    send_item(8'hFF, 16'h0000);
    send_item(8'h00, 16'h0001);
    send_item(8'hFF, 16'h0001);
    // two-byte frame, length on the inner byte ignored
    send_item(8'h5A, 16'h0002);
    send_item(8'hA5, 16'hFFFF);
    // check string "123456789"
    send_item(8'h31, 16'h0009);
    for (int i = 1; i < 9; i++) begin
      send_item(8'h31 + 8'(i), 16'(i * 4111));
    end
    // zero length inside a frame is only a byte
    send_item(8'h80, 16'h0003);
    send_item(8'h01, 16'h0000);
    send_item(8'h7F, 16'h5555);
    send_item(8'hC3, 16'h0000);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 16'h0000);
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_item(8'($urandom), 16'(len));
        sent++;
        for (int k = 1; k < len; k++) begin
          send_item(8'($urandom), 16'($urandom));
          sent++;
        end
      end
    end

    // maximum length: header only checked, frame left open at the end
    send_item(8'hE7, 16'hFFFF);
    send_item(8'h18, 16'h0000);
    send_item(8'hFF, 16'hFFFF);
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS crc16_packet_framer");
    end else begin
      $display("FAIL crc16_packet_framer");
    end
    $finish;
  end

endmodule

### files.f
sv/c16f_pkg.sv
sv/c16f_if.sv
sv/c16f_emit.sv
sv/crc16_packet_framer.sv
tb/crc16_packet_framer_checker.sv
tb/crc16_packet_framer_tb.sv
